### rtl/core/bsa_pkg.sv
// Package for the ascending batch sorter: capacity, widths, payload structs,
// cell link struct and sequencer states. No dependencies.
package bsa_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last_res;
		logic               overflow;
	} result_t;

	// One element travelling along the row or held in a cell.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
	} elem_t;

	// Row control from the sequencer.
	typedef struct packed {
		logic shift;
	} row_ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_DRAIN
	} state_t;

endpackage

### rtl/core/batch_sorter_ascending.sv
// Top level of the ascending batch sorter: load sequencer, row of sorting
// cells and result register. Depends on bsa_pkg and bsa_row.
//
// Usage:
//  - Input channel (item, item_valid, item_stall): one signed 32-bit value per
//    request; a request with item.last = 1 closes the batch. Loading does not
//    stall the input. Up to CAPACITY (64) values are kept; later requests of
//    the same batch are dropped and mark every result of the batch overflow.
//  - After the closing request the input stalls while the row settles: each
//    value ripples right one cell per cycle, and the drain waits until no
//    value is still moving right.
//  - Results (result, result_valid, result_stall) then leave one per cycle,
//    unless the result side stalls, in ascending order from cell 0 while the
//    row shifts left; last_res marks the greatest value.
//  - A stall on the result side holds the result register and freezes the
//    drain. The input reopens as soon as the final result sits in the result
//    register, so the next batch can load while it waits.
//  - Reset clears the cells' valid bits, the state, the count, the overflow flag and the result valid flag.
module batch_sorter_ascending (
	input  logic             clk,
	input  logic             arst_n,
	input  bsa_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_stall,
	output bsa_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_stall
);

	bsa_pkg::state_t         state_q;
	bsa_pkg::state_t         state_next;
	logic [bsa_pkg::CNT_W-1:0] count_q;
	logic                    ovf_q;
	logic                    result_valid_q;
	bsa_pkg::result_t        result_q;

	bsa_pkg::row_ctrl_t      row_ctrl;
	bsa_pkg::elem_t          inject;
	bsa_pkg::elem_t          head;
	logic                    row_busy;
	logic                    item_acc;
	logic                    has_room;
	logic                    take;
	logic                    final_take;

	assign has_room   = count_q < bsa_pkg::CNT_W'(bsa_pkg::CAPACITY);
	assign item_acc   = item_valid && !item_stall;
	assign final_take = take && (count_q == bsa_pkg::CNT_W'(1));

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			bsa_pkg::ST_LOAD: begin
				if (item_acc && item.last) begin
					state_next = bsa_pkg::ST_SETTLE;
				end
			end
			bsa_pkg::ST_SETTLE: begin
				if (!row_busy) begin
					state_next = bsa_pkg::ST_DRAIN;
				end
			end
			bsa_pkg::ST_DRAIN: begin
				if (final_take) begin
					state_next = bsa_pkg::ST_LOAD;
				end
			end
			default: state_next = bsa_pkg::ST_LOAD;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_stall     = 1'b1;
		take           = 1'b0;
		inject         = '0;
		case (state_q)
			bsa_pkg::ST_LOAD: begin
				item_stall   = 1'b0;
				inject.valid = item_acc && has_room;
				inject.value = item.value;
			end
			bsa_pkg::ST_DRAIN: begin
				// Pop the head whenever the result register is free or emptying.
				take = !result_valid_q || !result_stall;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
		row_ctrl.shift = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bsa_pkg::ST_LOAD;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (item_acc) begin
				if (has_room) begin
					count_q <= count_q + bsa_pkg::CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (take) begin
				// Count down remaining results; the batch is done at zero.
				count_q        <= count_q - bsa_pkg::CNT_W'(1);
				result_valid_q <= 1'b1;
				if (final_take) begin
					ovf_q <= 1'b0;
				end
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load on each pop.
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.value_res <= head.value;
			result_q.last_res  <= final_take;
			result_q.overflow  <= ovf_q;
		end
	end

	bsa_row u_row (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (row_ctrl),
		.inject(inject),
		.head  (head),
		.busy  (row_busy)
	);

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

### rtl/core/bsa_cell.sv
// One sorting cell: keeps the smaller of its held and incoming values and
// passes the larger one right, or shifts left. Depends on bsa_pkg.
module bsa_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bsa_pkg::row_ctrl_t ctrl,
	input  bsa_pkg::elem_t    from_left,
	input  bsa_pkg::elem_t    from_right,
	output bsa_pkg::elem_t    pass,
	output bsa_pkg::elem_t    held
);

	logic               held_valid_q;
	logic signed [31:0] held_value_q;
	logic               pass_valid_q;
	logic signed [31:0] pass_value_q;
	logic               take_in;

	assign take_in = !held_valid_q || (from_left.value < held_value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			held_valid_q <= from_right.valid;
			pass_valid_q <= 1'b0;
		end else begin
			pass_valid_q <= from_left.valid && held_valid_q;
			if (from_left.valid) begin
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_value_q <= from_right.value;
		end else if (from_left.valid) begin
			if (take_in) begin
				held_value_q <= from_left.value;
				pass_value_q <= held_value_q;
			end else begin
				pass_value_q <= from_left.value;
			end
		end
	end

	assign pass = '{valid: pass_valid_q, value: pass_value_q};
	assign held = '{valid: held_valid_q, value: held_value_q};

endmodule

### rtl/core/bsa_row.sv
// Row of CAPACITY sorting cells, smallest value in cell 0.
// Depends on bsa_pkg and bsa_cell.
module bsa_row (
	input  logic               clk,
	input  logic               arst_n,
	input  bsa_pkg::row_ctrl_t ctrl,
	input  bsa_pkg::elem_t     inject,
	output bsa_pkg::elem_t     head,
	output logic               busy
);

	bsa_pkg::elem_t pass_w [bsa_pkg::CAPACITY];
	bsa_pkg::elem_t held_w [bsa_pkg::CAPACITY];

	for (genvar i = 0; i < bsa_pkg::CAPACITY; i++) begin : g_cell
		bsa_pkg::elem_t left_w;
		bsa_pkg::elem_t right_w;

		if (i == 0) begin : g_first
			assign left_w = inject;
		end else begin : g_mid
			assign left_w = pass_w[i-1];
		end

		if (i == bsa_pkg::CAPACITY - 1) begin : g_end
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = held_w[i+1];
		end

		bsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.from_left (left_w),
			.from_right(right_w),
			.pass      (pass_w[i]),
			.held      (held_w[i])
		);
	end

	// Any element still moving right keeps the row from draining.
	always_comb begin
		busy = 1'b0;
		for (int i = 0; i < bsa_pkg::CAPACITY; i++) begin
			busy = busy | pass_w[i].valid;
		end
	end

	assign head = held_w[0];

endmodule
